// File: sv/flow_tuple_hash_dispatch_assert.svh
// Assertion macros for the flow hash dispatch block.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef FLOW_TUPLE_HASH_DISPATCH_ASSERT_SVH
`define FLOW_TUPLE_HASH_DISPATCH_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define FTD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ftd assertion failed");

// Next-cycle implication, checked out of reset.
`define FTD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ftd assertion failed");

`endif

// File: sv/ftd_pkg.sv
// Constants, types and CRC-16 helpers for the flow hash dispatch block.
// No dependencies.
package ftd_pkg;

  localparam int CRC_W  = 16;
  localparam int WORD_W = 64;
  localparam int BYTE_W = 8;

  localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
  localparam logic [CRC_W-1:0] CRC_SEED = 16'hFFFF;

  // register indexes (byte address = 4 * index)
  localparam int CFG_ADDR_W = 5;
  localparam logic [2:0] REG_USE_PROTOCOL = 3'd0;
  localparam logic [2:0] REG_FOLD_TO_BYTE = 3'd1;
  localparam logic [2:0] REG_WEIGHT_TOTAL = 3'd2;
  localparam logic [2:0] REG_WEIGHT_CORE0 = 3'd3;
  localparam logic [2:0] REG_WEIGHT_CORE1 = 3'd4;

  localparam logic        RST_USE_PROTOCOL = 1'b0;
  localparam logic        RST_FOLD_TO_BYTE = 1'b1;
  localparam logic [15:0] RST_WEIGHT_TOTAL = 16'd10;
  localparam logic [15:0] RST_WEIGHT_CORE0 = 16'd4;
  localparam logic [15:0] RST_WEIGHT_CORE1 = 16'd6;

  // pipeline: three CRC stages, one combine stage, one divider stage per
  // hash bit, one output stage
  localparam int FRONT_STAGES   = 4;
  localparam int NUM_DIV_STAGES = CRC_W;
  localparam int NUM_STAGES     = FRONT_STAGES + NUM_DIV_STAGES + 1;

  typedef logic [WORD_W-1:0][CRC_W-1:0] word_cols_t;
  typedef logic [CRC_W-1:0][CRC_W-1:0]  state_cols_t;

  // Bit-serial CRC; only evaluated at elaboration to build the matrices.
  function automatic logic [CRC_W-1:0] crc_serial(logic [CRC_W-1:0] c,
                                                  logic [WORD_W-1:0] w);
    logic [CRC_W-1:0] r;
    r = c;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (r[CRC_W-1] ^ w[i]) begin
        r = {r[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        r = {r[CRC_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  function automatic word_cols_t mk_word_cols();
    word_cols_t cols;
    for (int i = 0; i < WORD_W; i++) begin
      cols[i] = crc_serial('0, WORD_W'(1) << i);
    end
    return cols;
  endfunction

  function automatic state_cols_t mk_state_cols();
    state_cols_t cols;
    for (int j = 0; j < CRC_W; j++) begin
      cols[j] = crc_serial(CRC_W'(1) << j, '0);
    end
    return cols;
  endfunction

  localparam word_cols_t  WORD_COLS  = mk_word_cols();
  localparam state_cols_t STATE_COLS = mk_state_cols();

  // CRC over one 64-bit word: the CRC is linear, so each set bit of the
  // word and of the old state adds a fixed column (flat XOR tree).
  function automatic logic [CRC_W-1:0] crc_word(logic [CRC_W-1:0] c,
                                                logic [WORD_W-1:0] w);
    logic [CRC_W-1:0] r;
    r = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (w[i]) r = r ^ WORD_COLS[i];
    end
    for (int j = 0; j < CRC_W; j++) begin
      if (c[j]) r = r ^ STATE_COLS[j];
    end
    return r;
  endfunction

endpackage

// File: sv/flow_tuple_hash_dispatch.sv
// Flow hash and core dispatch: CRC-16 tuple hash, remainder, range lookup (ftd_pkg, assert macros).
// Takes one request per cycle unless a stalled output has backed up every stage.
// Stages: word0, word1, ports, combine/fold, 16 restoring-divider stages
// (one hash bit each, set by the 16-bit hash width), output register.
// Empty stages fill while the output is stalled. Reset (rst_n low, sync)
// clears all valid bits and loads the register defaults.
`include "flow_tuple_hash_dispatch_assert.svh"

module flow_tuple_hash_dispatch
  import ftd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_is_ipv6,
  input  logic                  in_include_ports,
  input  logic [WORD_W-1:0]     in_src_word0,
  input  logic [WORD_W-1:0]     in_src_word1,
  input  logic [WORD_W-1:0]     in_dst_word0,
  input  logic [WORD_W-1:0]     in_dst_word1,
  input  logic [15:0]           in_src_port,
  input  logic [15:0]           in_dst_port,
  input  logic [7:0]            in_protocol,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CRC_W-1:0]      out_flow_hash,
  output logic                  out_core_index,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int LAST = NUM_STAGES - 1;
  localparam int DLST = NUM_DIV_STAGES - 1;

  // configuration registers
  logic        use_protocol_r;
  logic        fold_to_byte_r;
  logic [15:0] weight_total_r;
  logic [15:0] weight_core0_r;
  logic [15:0] weight_core1_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_protocol_r <= RST_USE_PROTOCOL;
      fold_to_byte_r <= RST_FOLD_TO_BYTE;
      weight_total_r <= RST_WEIGHT_TOTAL;
      weight_core0_r <= RST_WEIGHT_CORE0;
      weight_core1_r <= RST_WEIGHT_CORE1;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_USE_PROTOCOL: use_protocol_r <= pwdata[0];
        REG_FOLD_TO_BYTE: fold_to_byte_r <= pwdata[0];
        REG_WEIGHT_TOTAL: weight_total_r <= pwdata[15:0];
        REG_WEIGHT_CORE0: weight_core0_r <= pwdata[15:0];
        REG_WEIGHT_CORE1: weight_core1_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_USE_PROTOCOL: prdata = {31'b0, use_protocol_r};
      REG_FOLD_TO_BYTE: prdata = {31'b0, fold_to_byte_r};
      REG_WEIGHT_TOTAL: prdata = {16'b0, weight_total_r};
      REG_WEIGHT_CORE0: prdata = {16'b0, weight_core0_r};
      REG_WEIGHT_CORE1: prdata = {16'b0, weight_core1_r};
      default:          prdata = '0;
    endcase
  end

  // valid bits and per-stage advance; a stage loads when it is empty or
  // its contents move on
  logic [NUM_STAGES-1:0] v_r;
  logic [NUM_STAGES-1:0] go;

  always_comb begin
    go[LAST] = !v_r[LAST] || !out_stall;
    for (int k = LAST - 1; k >= 0; k--) begin
      go[k] = !v_r[k] || go[k+1];
    end
  end

  assign in_stall  = !go[0];
  assign out_valid = v_r[LAST];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (go[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (go[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // stage 1: first word (IPv4 address sits in the top half), protocol CRC
  logic [CRC_W-1:0]  s1_src_crc_r, s1_dst_crc_r, s1_prot_crc_r;
  logic              s1_v6_r, s1_ports_r;
  logic [WORD_W-1:0] s1_src_w1_r, s1_dst_w1_r;
  logic [15:0]       s1_sport_r, s1_dport_r;
  logic [WORD_W-1:0] src_w0_nxt, dst_w0_nxt;

  assign src_w0_nxt = in_is_ipv6 ? in_src_word0 : {in_src_word0[31:0], 32'b0};
  assign dst_w0_nxt = in_is_ipv6 ? in_dst_word0 : {in_dst_word0[31:0], 32'b0};

  always_ff @(posedge clk) begin
    if (go[0]) begin
      s1_src_crc_r  <= crc_word(CRC_SEED, src_w0_nxt);
      s1_dst_crc_r  <= crc_word(CRC_SEED, dst_w0_nxt);
      s1_prot_crc_r <= use_protocol_r ?
                       crc_word(CRC_SEED, {in_protocol, {(WORD_W-BYTE_W){1'b0}}}) :
                       CRC_SEED;
      s1_v6_r       <= in_is_ipv6;
      s1_ports_r    <= in_include_ports;
      s1_src_w1_r   <= in_src_word1;
      s1_dst_w1_r   <= in_dst_word1;
      s1_sport_r    <= in_src_port;
      s1_dport_r    <= in_dst_port;
    end
  end

  // stage 2: second IPv6 word
  logic [CRC_W-1:0] s2_src_crc_r, s2_dst_crc_r, s2_prot_crc_r;
  logic             s2_ports_r;
  logic [15:0]      s2_sport_r, s2_dport_r;

  always_ff @(posedge clk) begin
    if (go[1]) begin
      s2_src_crc_r  <= s1_v6_r ? crc_word(s1_src_crc_r, s1_src_w1_r) : s1_src_crc_r;
      s2_dst_crc_r  <= s1_v6_r ? crc_word(s1_dst_crc_r, s1_dst_w1_r) : s1_dst_crc_r;
      s2_prot_crc_r <= s1_prot_crc_r;
      s2_ports_r    <= s1_ports_r;
      s2_sport_r    <= s1_sport_r;
      s2_dport_r    <= s1_dport_r;
    end
  end

  // stage 3: port as two bytes plus six zero bytes
  logic [CRC_W-1:0] s3_src_crc_r, s3_dst_crc_r, s3_prot_crc_r;

  always_ff @(posedge clk) begin
    if (go[2]) begin
      s3_src_crc_r  <= s2_ports_r ? crc_word(s2_src_crc_r, {s2_sport_r, 48'b0}) :
                       s2_src_crc_r;
      s3_dst_crc_r  <= s2_ports_r ? crc_word(s2_dst_crc_r, {s2_dport_r, 48'b0}) :
                       s2_dst_crc_r;
      s3_prot_crc_r <= s2_prot_crc_r;
    end
  end

  // stage 4: combine and fold
  logic [CRC_W-1:0] s4_hash_r;
  logic [CRC_W-1:0] mix_nxt;

  assign mix_nxt = s3_src_crc_r ^ s3_dst_crc_r ^ s3_prot_crc_r;

  always_ff @(posedge clk) begin
    if (go[3]) begin
      s4_hash_r <= fold_to_byte_r ? {8'b0, mix_nxt[7:0] ^ mix_nxt[15:8]} : mix_nxt;
    end
  end

  // restoring remainder, MSB first, one hash bit per stage
  logic [CRC_W-1:0] dv_hash_r [NUM_DIV_STAGES];
  logic [CRC_W-1:0] dv_rem_r  [NUM_DIV_STAGES];
  logic [CRC_W-1:0] dv_rem_nxt[NUM_DIV_STAGES];

  for (genvar j = 0; j < NUM_DIV_STAGES; j++) begin : g_div
    logic [CRC_W-1:0] hash_in;
    logic [CRC_W-1:0] rem_in;
    logic [CRC_W:0]   trial;
    logic [CRC_W:0]   diff;

    if (j == 0) begin : g_first
      assign hash_in = s4_hash_r;
      assign rem_in  = '0;
    end else begin : g_rest
      assign hash_in = dv_hash_r[j-1];
      assign rem_in  = dv_rem_r[j-1];
    end

    assign trial = {rem_in, hash_in[CRC_W-1-j]};
    assign diff  = trial - {1'b0, weight_total_r};

    always_comb begin
      if (trial >= {1'b0, weight_total_r}) begin
        dv_rem_nxt[j] = diff[CRC_W-1:0];
      end else begin
        dv_rem_nxt[j] = trial[CRC_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (go[FRONT_STAGES+j]) begin
        dv_hash_r[j] <= hash_in;
        dv_rem_r[j]  <= dv_rem_nxt[j];
      end
    end
  end

  // output stage: range lookup; a zero modulus passes the hash through
  logic [CRC_W-1:0] out_flow_hash_r;
  logic             out_core_index_r;
  logic [CRC_W-1:0] rem_fin;
  logic [CRC_W:0]   edge1;
  logic             core_nxt;

  assign rem_fin  = (weight_total_r == '0) ? dv_hash_r[DLST] : dv_rem_r[DLST];
  assign edge1    = {1'b0, weight_core0_r} + {1'b0, weight_core1_r};
  assign core_nxt = (rem_fin >= weight_core0_r) && ({1'b0, rem_fin} < edge1);

  always_ff @(posedge clk) begin
    if (go[LAST]) begin
      out_flow_hash_r  <= dv_hash_r[DLST];
      out_core_index_r <= core_nxt;
    end
  end

  assign out_flow_hash  = out_flow_hash_r;
  assign out_core_index = out_core_index_r;

  // a refused request means every stage holds an item behind a stalled output
  `FTD_ASSERT_IMPL(a_stall_only_when_full, in_stall, (&v_r) && out_stall)
  // divider result is a true remainder
  `FTD_ASSERT_IMPL(a_rem_below_total, v_r[LAST-1] && (weight_total_r != '0),
                   dv_rem_r[DLST] < weight_total_r)
  // folded hash keeps its upper byte clear
  `FTD_ASSERT_IMPL(a_fold_upper_zero, out_valid && fold_to_byte_r,
                   out_flow_hash[15:8] == 8'b0)
  // an item in the last divider stage reaches the output register next
  `FTD_ASSERT_NEXT(a_drain_to_output, v_r[LAST-1] && go[LAST-1], out_valid)

endmodule

// File: verif/tb_flow_tuple_hash_dispatch.sv
// Self-checking testbench for flow_tuple_hash_dispatch: CRC-16 flow hash and core pick.
// Needs ftd_pkg and the block's RTL; a local predictor computes the expected results.
`timescale 1ns / 100ps

module tb_flow_tuple_hash_dispatch;
  import ftd_pkg::*;

  // index with no register behind it
  localparam logic [2:0] REG_UNUSED = 3'd5;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int RAND_PHASES = 8;
  localparam int REQS_PER_PHASE = 100;

  typedef struct {
    logic        v6;
    logic        ports;
    logic [63:0] src0;
    logic [63:0] src1;
    logic [63:0] dst0;
    logic [63:0] dst1;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  proto;
  } flow_req_t;

  typedef struct {
    logic [15:0] hash;
    logic        core;
  } flow_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_is_ipv6 = 1'b0;
  logic              in_include_ports = 1'b0;
  logic [WORD_W-1:0] in_src_word0 = '0;
  logic [WORD_W-1:0] in_src_word1 = '0;
  logic [WORD_W-1:0] in_dst_word0 = '0;
  logic [WORD_W-1:0] in_dst_word1 = '0;
  logic [15:0]       in_src_port = '0;
  logic [15:0]       in_dst_port = '0;
  logic [7:0]        in_protocol = '0;

  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [CRC_W-1:0]  out_flow_hash;
  logic              out_core_index;

  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  // register shadow
  logic        cfg_use_prot = RST_USE_PROTOCOL;
  logic        cfg_fold = RST_FOLD_TO_BYTE;
  logic [15:0] cfg_total = RST_WEIGHT_TOTAL;
  logic [15:0] cfg_core0 = RST_WEIGHT_CORE0;
  logic [15:0] cfg_core1 = RST_WEIGHT_CORE1;

  flow_req_t pend_reqs[$];
  flow_res_t exp_results[$];
  flow_req_t cur_req;
  logic      req_taken = 1'b0;
  int        src_gap = 0;
  int        sink_burst = 0;
  int        sink_hold_left = 0;
  logic      sink_hold_req = 1'b0;
  logic      sink_hold_done = 1'b0;
  logic      gaps_on = 1'b1;
  int        err_cnt = 0;

  flow_tuple_hash_dispatch i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_is_ipv6(in_is_ipv6),
    .in_include_ports(in_include_ports),
    .in_src_word0(in_src_word0),
    .in_src_word1(in_src_word1),
    .in_dst_word0(in_dst_word0),
    .in_dst_word1(in_dst_word1),
    .in_src_port(in_src_port),
    .in_dst_port(in_dst_port),
    .in_protocol(in_protocol),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_flow_hash(out_flow_hash),
    .out_core_index(out_core_index),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  // ---------------- hash predictor ----------------

  // unreflected CRC-16, 64-bit word, MSB first
  function automatic logic [15:0] crc16_word(logic [15:0] crc, logic [63:0] data);
    logic [15:0] c;
    logic fb;
    c = crc;
    for (int b = 63; b >= 0; b--) begin
      fb = c[15] ^ data[b];
      c = {c[14:0], 1'b0};
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  function automatic logic [15:0] side_crc16(logic v6, logic [63:0] w0, logic [63:0] w1,
                                             logic ports, logic [15:0] port);
    logic [15:0] c;
    if (v6) begin
      c = crc16_word(crc16_word(CRC_SEED, w0), w1);
    end else begin
      c = crc16_word(CRC_SEED, {w0[31:0], 32'd0});
    end
    if (ports) c = crc16_word(c, {port, 48'd0});
    return c;
  endfunction

  function automatic flow_res_t predict_flow(flow_req_t r);
    logic [15:0] h;
    logic [15:0] p;
    logic [15:0] rem;
    logic [16:0] lim0;
    logic [16:0] lim1;
    flow_res_t res;
    p = cfg_use_prot ? crc16_word(CRC_SEED, {r.proto, 56'd0}) : CRC_SEED;
    h = side_crc16(r.v6, r.src0, r.src1, r.ports, r.sport)
        ^ side_crc16(r.v6, r.dst0, r.dst1, r.ports, r.dport) ^ p;
    if (cfg_fold) h = {8'd0, h[7:0] ^ h[15:8]};
    // zero modulus leaves the hash as is
    rem = (cfg_total != 16'd0) ? (h % cfg_total) : h;
    lim0 = {1'b0, cfg_core0};
    lim1 = lim0 + {1'b0, cfg_core1};
    res.hash = h;
    if ({1'b0, rem} < lim0) res.core = 1'b0;
    else if ({1'b0, rem} < lim1) res.core = 1'b1;
    else res.core = 1'b0;
    return res;
  endfunction

  task automatic flag_error(input string what);
    err_cnt++;
    if (err_cnt <= 10) $display("%0t ns: %s", $time, what);
  endtask

  // ---------------- request driver ----------------

  always @(negedge clk) begin
    if (rst_n && (!in_valid || req_taken)) begin
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        in_valid <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        src_gap <= $urandom_range(0, 15);
        in_valid <= 1'b0;
      end else if (pend_reqs.size() > 0) begin
        cur_req = pend_reqs.pop_front();
        in_is_ipv6 <= cur_req.v6;
        in_include_ports <= cur_req.ports;
        in_src_word0 <= cur_req.src0;
        in_src_word1 <= cur_req.src1;
        in_dst_word0 <= cur_req.dst0;
        in_dst_word1 <= cur_req.dst1;
        in_src_port <= cur_req.sport;
        in_dst_port <= cur_req.dport;
        in_protocol <= cur_req.proto;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------- result-side stall ----------------

  always @(negedge clk) begin
    if (sink_hold_left > 0) begin
      sink_hold_left <= sink_hold_left - 1;
    end else if (sink_hold_req && !sink_hold_done) begin
      sink_hold_left <= LONG_HOLD_CYCLES;
      sink_hold_done <= 1'b1;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (sink_hold_left > 0) begin
      out_stall <= 1'b1;
    end else if (sink_burst > 0) begin
      sink_burst <= sink_burst - 1;
      out_stall <= 1'b1;
    end else if (gaps_on && $urandom_range(0, 11) == 0) begin
      sink_burst <= $urandom_range(0, 15);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------- monitor: predict on accept, check on result ----------------

  always @(posedge clk) begin
    flow_req_t seen;
    flow_res_t want;
    req_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      seen.v6 = in_is_ipv6;
      seen.ports = in_include_ports;
      seen.src0 = in_src_word0;
      seen.src1 = in_src_word1;
      seen.dst0 = in_dst_word0;
      seen.dst1 = in_dst_word1;
      seen.sport = in_src_port;
      seen.dport = in_dst_port;
      seen.proto = in_protocol;
      exp_results.push_back(predict_flow(seen));
    end
    if (rst_n && out_valid && !out_stall) begin
      if (exp_results.size() == 0) begin
        flag_error($sformatf("unexpected result hash=%h core=%0d",
                             out_flow_hash, out_core_index));
      end else begin
        want = exp_results.pop_front();
        if (out_flow_hash !== want.hash)
          flag_error($sformatf("flow_hash: expected %h, got %h", want.hash, out_flow_hash));
        if (out_core_index !== want.core)
          flag_error($sformatf("core_index: expected %0d, got %0d",
                               want.core, out_core_index));
      end
    end
  end

  // ---------------- configuration ----------------

  function automatic logic [31:0] shadow_value(logic [2:0] idx);
    case (idx)
      REG_USE_PROTOCOL: return {31'd0, cfg_use_prot};
      REG_FOLD_TO_BYTE: return {31'd0, cfg_fold};
      REG_WEIGHT_TOTAL: return {16'd0, cfg_total};
      REG_WEIGHT_CORE0: return {16'd0, cfg_core0};
      REG_WEIGHT_CORE1: return {16'd0, cfg_core1};
      default: return 32'd0;
    endcase
  endfunction

  // write one register, then read it back while the bus is still ours
  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_USE_PROTOCOL: cfg_use_prot = val[0];
      REG_FOLD_TO_BYTE: cfg_fold = val[0];
      REG_WEIGHT_TOTAL: cfg_total = val[15:0];
      REG_WEIGHT_CORE0: cfg_core0 = val[15:0];
      REG_WEIGHT_CORE1: cfg_core1 = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx != REG_UNUSED && prdata !== shadow_value(idx))
      flag_error($sformatf("register %0d read: expected %h, got %h",
                           idx, shadow_value(idx), prdata));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_cfg(input logic up, input logic fb, input logic [15:0] tot,
                           input logic [15:0] c0, input logic [15:0] c1);
    cfg_write(REG_USE_PROTOCOL, {$urandom} & ~32'd1 | {31'd0, up});
    cfg_write(REG_FOLD_TO_BYTE, {31'd0, fb});
    cfg_write(REG_WEIGHT_TOTAL, {16'd0, tot});
    cfg_write(REG_WEIGHT_CORE0, {16'd0, c0});
    cfg_write(REG_WEIGHT_CORE1, {16'd0, c1});
  endtask

  // ---------------- stimulus ----------------

  task automatic push_req(input logic v6, input logic ports, input logic [63:0] s0,
                          input logic [63:0] s1, input logic [63:0] d0, input logic [63:0] d1,
                          input logic [15:0] sp, input logic [15:0] dp, input logic [7:0] pr);
    flow_req_t r;
    r.v6 = v6;
    r.ports = ports;
    r.src0 = s0;
    r.src1 = s1;
    r.dst0 = d0;
    r.dst1 = d1;
    r.sport = sp;
    r.dport = dp;
    r.proto = pr;
    pend_reqs.push_back(r);
  endtask

  function automatic logic [63:0] rand_word();
    logic [63:0] w;
    case ($urandom_range(0, 15))
      0: w = '0;
      1: w = '1;
      default: w = {$urandom, $urandom};
    endcase
    return w;
  endfunction

  task automatic push_rand_req();
    push_req(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), rand_word(), rand_word(),
             rand_word(), rand_word(), 16'($urandom_range(0, 65535)),
             16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (pend_reqs.size() != 0 || in_valid || exp_results.size() != 0);
  endtask

  initial begin
    logic [15:0] tot;
    logic [15:0] span;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // reset defaults: IPv4/IPv6 extremes, upper IPv4 bits ignored, ports on and off
    push_req(1'b0, 1'b0, '0, '0, '0, '0, 16'h0000, 16'h0000, 8'h00);
    push_req(1'b0, 1'b1, '1, '1, '1, '1, 16'hFFFF, 16'hFFFF, 8'hFF);
    push_req(1'b0, 1'b0, 64'hFFFF_FFFF_0000_0000, '1, 64'hA5A5_A5A5_0000_0000, '1,
             16'h1234, 16'h4321, 8'h06);
    push_req(1'b1, 1'b0, '0, '0, '0, '0, 16'h0000, 16'h0000, 8'h00);
    push_req(1'b1, 1'b1, '1, '1, '1, '1, 16'hFFFF, 16'hFFFF, 8'hFF);
    push_req(1'b1, 1'b1, {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
             {$urandom, $urandom}, 16'h0000, 16'hFFFF, 8'h11);
    push_rand_req();
    wait_drained();

    // protocol mixed in, unfolded, zero modulus, ranges halving the hash space
    apply_cfg(1'b1, 1'b0, 16'd0, 16'h8000, 16'h8000);
    push_req(1'b0, 1'b0, '0, '0, '0, '0, 16'h0000, 16'h0000, 8'h00);
    push_req(1'b0, 1'b0, '0, '0, '0, '0, 16'h0000, 16'h0000, 8'hFF);
    push_rand_req();
    push_rand_req();
    wait_drained();

    // modulus 1, empty ranges: nothing matches
    apply_cfg(1'b0, 1'b0, 16'd1, 16'd0, 16'd0);
    push_rand_req();
    push_rand_req();
    wait_drained();

    // widest weights: bounds need the 17th bit, every remainder falls in core 0's range
    apply_cfg(1'b1, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_rand_req();
    push_req(1'b1, 1'b1, '1, '1, '0, '0, 16'hFFFF, 16'h0000, 8'h80);
    wait_drained();

    // folded, core 0 empty so core 1 owns everything
    apply_cfg(1'b0, 1'b1, 16'd256, 16'd0, 16'd300);
    push_rand_req();
    push_rand_req();
    push_rand_req();
    wait_drained();

    // write to an unmapped index must not disturb anything; leave a gap region
    cfg_write(REG_UNUSED, 32'hFFFF_FFFF);
    apply_cfg(1'b1, 1'b1, 16'd7, 16'd3, 16'd2);
    repeat (5) push_rand_req();
    wait_drained();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      gaps_on = (ph != 5 && ph != RAND_PHASES - 1);
      case (ph)
        0: apply_cfg(1'b1, 1'b0, 16'hFFFF, 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535)));
        1: apply_cfg(1'b0, 1'b1, 16'd1, 16'($urandom_range(0, 1)), 16'($urandom_range(0, 1)));
        2: apply_cfg(1'b1, 1'b1, 16'd0, 16'($urandom_range(0, 255)),
                     16'($urandom_range(0, 255)));
        default: begin
          case ($urandom_range(0, 3))
            0: tot = 16'd0;
            1: tot = 16'($urandom_range(1, 20));
            2: tot = 16'($urandom_range(1, 300));
            default: tot = 16'($urandom_range(1, 65535));
          endcase
          span = (tot == 16'd0) ? 16'd256 : tot;
          apply_cfg(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), tot,
                    16'($urandom_range(0, span)), 16'($urandom_range(0, span)));
        end
      endcase
      for (int n = 0; n < REQS_PER_PHASE; n++) push_rand_req();
      // receiver holds off while requests keep coming: pipeline backs up
      if (ph == 3) sink_hold_req = 1'b1;
      wait_drained();
    end

    repeat (40) @(negedge clk);
    if (err_cnt == 0 && exp_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
